// ===== rtl/core/irpu_pkg.sv =====
package irpu_pkg;

  // Size limits of the source image and of the enlargement factor.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_RATIO  = 8;

  // Field widths that the interface fixes.
  localparam int COLOR_W = 8;
  localparam int ADDR_W  = 26;
  localparam int RAT_W   = 4;
  localparam int SIZE_W  = 11;

  // Configuration port.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = SIZE_W;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  // Register values after reset.
  localparam logic [RAT_W-1:0]  RST_RATIO  = 4'd2;
  localparam logic [SIZE_W-1:0] RST_WIDTH  = 11'd640;
  localparam logic [SIZE_W-1:0] RST_HEIGHT = 11'd480;

  // Internal widths derived from the limits.
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int CNT_W  = ((COL_W > SIZE_W) ? COL_W : SIZE_W) + 1;
  localparam int RCNT_W = ((ROW_W > SIZE_W) ? ROW_W : SIZE_W) + 1;
  localparam int X_W    = $clog2(MAX_WIDTH * MAX_RATIO);
  localparam int Y_W    = $clog2(MAX_HEIGHT * MAX_RATIO);
  localparam int DW_W   = $clog2(MAX_WIDTH * MAX_RATIO + 1);
  localparam int PROD_W = Y_W + DW_W;
  localparam int D_W    = $clog2(MAX_RATIO);

  typedef struct packed {
    logic [COLOR_W-1:0] red_in;
    logic [COLOR_W-1:0] green_in;
    logic [COLOR_W-1:0] blue_in;
  } in_pix_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  dest_address;
    logic [COLOR_W-1:0] red_out;
    logic [COLOR_W-1:0] green_out;
    logic [COLOR_W-1:0] blue_out;
    logic               block_last;
    logic               frame_end;
  } out_wr_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic load_base;
    logic emit;
    logic step_col;
    logic step_row;
    logic blk_last;
  } irpu_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [RAT_W-1:0] ratio;
    logic             out_free;
  } irpu_stat_t;

endpackage

// ===== rtl/core/irpu_ctrl.sv =====
module irpu_ctrl
  import irpu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  irpu_stat_t stat,
  output irpu_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BASE = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]     state_r, state_nxt;
  logic [D_W-1:0] dx_r, dx_nxt;
  logic [D_W-1:0] dy_r, dy_nxt;
  logic           dx_end, dy_end;

  // Position inside the replicated block.
  assign dx_end = (RAT_W'(dx_r) == stat.ratio - RAT_W'(1));
  assign dy_end = (RAT_W'(dy_r) == stat.ratio - RAT_W'(1));

  assign in_stall = (state_r != ST_IDLE);

  // Sequencing of one source pixel: capture, base address, block writes.
  always_comb begin
    state_nxt    = state_r;
    dx_nxt       = dx_r;
    dy_nxt       = dy_r;
    cmd          = '0;
    cmd.blk_last = dx_end && dy_end;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_BASE;
        end
      end
      ST_BASE: begin
        cmd.load_base = 1'b1;
        dx_nxt        = '0;
        dy_nxt        = '0;
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (!dx_end) begin
            cmd.step_col = 1'b1;
            dx_nxt       = dx_r + D_W'(1);
          end else if (!dy_end) begin
            cmd.step_row = 1'b1;
            dx_nxt       = '0;
            dy_nxt       = dy_r + D_W'(1);
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      dx_r    <= '0;
      dy_r    <= '0;
    end else begin
      state_r <= state_nxt;
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
    end
  end

endmodule

// ===== rtl/core/irpu_dp.sv =====
module irpu_dp
  import irpu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  in_pix_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_wr_t              out_data,
  input  irpu_cmd_t            cmd,
  output irpu_stat_t           stat
);

  logic [RAT_W-1:0]  ratio_r;
  logic [SIZE_W-1:0] width_r, height_r;
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic [RAT_W-1:0]  r_eff;
  logic [CNT_W-1:0]  w_eff;
  logic [RCNT_W-1:0] h_eff;
  logic              last_col, last_row;
  in_pix_t           pix_r;
  logic [Y_W-1:0]    y0_r;
  logic [X_W-1:0]    x0_r;
  logic [DW_W-1:0]   dw_r;
  logic              lastc_r, lastr_r;
  logic [PROD_W-1:0] prod;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] addr_r, rowstart_r, next_rowstart;
  logic              out_valid_r;
  out_wr_t           out_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r  <= RST_RATIO;
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RATIO:  ratio_r  <= cfg_data[RAT_W-1:0];
        CFG_WIDTH:  width_r  <= cfg_data[SIZE_W-1:0];
        CFG_HEIGHT: height_r <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the settings into their usable ranges; zero acts as one.
  always_comb begin
    if (ratio_r == '0) begin
      r_eff = RAT_W'(1);
    end else if (ratio_r > RAT_W'(MAX_RATIO)) begin
      r_eff = RAT_W'(MAX_RATIO);
    end else begin
      r_eff = ratio_r;
    end
    if (width_r == '0) begin
      w_eff = CNT_W'(1);
    end else if (CNT_W'(width_r) > CNT_W'(MAX_WIDTH)) begin
      w_eff = CNT_W'(MAX_WIDTH);
    end else begin
      w_eff = CNT_W'(width_r);
    end
    if (height_r == '0) begin
      h_eff = RCNT_W'(1);
    end else if (RCNT_W'(height_r) > RCNT_W'(MAX_HEIGHT)) begin
      h_eff = RCNT_W'(MAX_HEIGHT);
    end else begin
      h_eff = RCNT_W'(height_r);
    end
  end

  // The counters wrap once they reach the size, even after a size change.
  assign last_col = (CNT_W'(col_r) + CNT_W'(1)) >= w_eff;
  assign last_row = (RCNT_W'(row_r) + RCNT_W'(1)) >= h_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.capture) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  // On the input transfer: color, scaled position and scaled width.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pix_r   <= in_data;
      y0_r    <= Y_W'(row_r) * Y_W'(r_eff);
      x0_r    <= X_W'(col_r) * X_W'(r_eff);
      dw_r    <= DW_W'(w_eff) * DW_W'(r_eff);
      lastc_r <= last_col;
      lastr_r <= last_row;
    end
  end

  // Address of the top left write of the block, kept to the address width.
  assign prod          = PROD_W'(y0_r) * PROD_W'(dw_r);
  assign base          = ADDR_W'(prod) + ADDR_W'(x0_r);
  assign next_rowstart = rowstart_r + ADDR_W'(dw_r);

  // Walk the block: next column, or start of the next destination row.
  always_ff @(posedge clk) begin
    if (cmd.load_base) begin
      addr_r     <= base;
      rowstart_r <= base;
    end else if (cmd.step_row) begin
      addr_r     <= next_rowstart;
      rowstart_r <= next_rowstart;
    end else if (cmd.step_col) begin
      addr_r <= addr_r + ADDR_W'(1);
    end
  end

  // Output register: loads when empty or when its result is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.dest_address <= addr_r;
      out_r.red_out      <= pix_r.red_in;
      out_r.green_out    <= pix_r.green_in;
      out_r.blue_out     <= pix_r.blue_in;
      out_r.block_last   <= cmd.blk_last;
      out_r.frame_end    <= cmd.blk_last && lastc_r && lastr_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_r;
  assign stat.ratio    = r_eff;
  assign stat.out_free = !out_valid_r || !out_stall;

endmodule

// ===== rtl/core/integer_ratio_pixel_upscaler_unit.sv =====
// Nearest-neighbor integer upscaler. Source RGB pixels come in raster order, one per
// input transfer; each one is replicated into a ratio x ratio block of destination
// writes, row by row and left to right, each carrying the pixel index in the
// enlarged frame and the color. block_last marks the final write of each block and
// frame_end the final write of the last source pixel of the frame. Column and row
// counters wrap at the programmed source size; program the registers only while the
// block is idle. Each source pixel goes through the input transfer with the scaled
// position products, then the base address multiply, then one write per cycle from
// the single output register while the output is not stalled. The next pixel is
// taken while the final write still waits.
module integer_ratio_pixel_upscaler_unit
  import irpu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_pix_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_wr_t              out_data
);

  irpu_cmd_t  cmd;
  irpu_stat_t stat;

  // Sequencer for one source pixel.
  irpu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Settings, counters, address generation and output register.
  irpu_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ===== rtl/core/irpu_chk.sv =====
module irpu_chk
  import irpu_pkg::*;
(
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_stall,
  input logic    out_valid,
  input logic    out_stall,
  input out_wr_t out_data
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // The end of the frame is always the end of a block.
  a_frame_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_end |-> out_data.block_last)
    else $error("frame_end without block_last");

  // While a block is still being written no new pixel is taken.
  a_no_take_mid_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.block_last |-> in_stall)
    else $error("input open in the middle of a block");

  // A pixel transfer is followed by work on that pixel.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not held off after a transfer");

endmodule

bind integer_ratio_pixel_upscaler_unit irpu_chk u_irpu_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/sv/upscale_write_checker.sv =====
// Watches the pixel and write channels of the upscaler, keeps its own copy of the
// scale and size registers and of the source position, and compares every
// destination write against the block of writes predicted for each source pixel.
module upscale_write_checker
  import irpu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_pix_t              in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_wr_t              out_data,
  output int                   fail_count,
  output int                   pending_writes,
  output int                   pixels_taken,
  output int                   writes_checked,
  output int                   frames_closed
);

  // Shadow copies of the registers and of the source position.
  logic [RAT_W-1:0]  ratio_reg;
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;
  logic [COL_W-1:0]  src_col;
  logic [ROW_W-1:0]  src_row;

  // Destination writes still owed by the block, oldest first.
  out_wr_t expected_writes[$];

  // Prints one line per mismatch and counts every one.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Zero acts as one, anything above the limit acts as the limit.
  function automatic int unsigned clamp_to(input int unsigned v, input int unsigned hi);
    if (v < 1) begin
      return 1;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  // Expands one source pixel into its ratio x ratio block of writes and moves the
  // source position on, wrapping at the effective size.
  task automatic predict_block(input in_pix_t px);
    int unsigned     r;
    int unsigned     w;
    int unsigned     h;
    longint unsigned dest_w;
    longint unsigned y;
    longint unsigned x;
    logic            last_col;
    logic            last_row;
    out_wr_t         wr;
    r = clamp_to(int'(ratio_reg), MAX_RATIO);
    w = clamp_to(int'(width_reg), MAX_WIDTH);
    h = clamp_to(int'(height_reg), MAX_HEIGHT);
    dest_w = longint'(w) * r;
    last_col = (int'(src_col) + 1) >= w;
    last_row = (int'(src_row) + 1) >= h;
    for (int unsigned dy = 0; dy < r; dy++) begin
      for (int unsigned dx = 0; dx < r; dx++) begin
        y = longint'(src_row) * r + dy;
        x = longint'(src_col) * r + dx;
        wr.dest_address = ADDR_W'(y * dest_w + x);
        wr.red_out = px.red_in;
        wr.green_out = px.green_in;
        wr.blue_out = px.blue_in;
        wr.block_last = (dy + 1 == r) && (dx + 1 == r);
        wr.frame_end = wr.block_last && last_col && last_row;
        expected_writes.push_back(wr);
      end
    end
    if (last_col) begin
      src_col = '0;
      src_row = last_row ? '0 : src_row + 1'b1;
    end else begin
      src_col = src_col + 1'b1;
    end
  endtask

  // Everything is sampled on the rising edge; the testbench drives on the falling one.
  always @(posedge clk) begin
    out_wr_t want;
    if (!rst_n) begin
      ratio_reg = RST_RATIO;
      width_reg = RST_WIDTH;
      height_reg = RST_HEIGHT;
      src_col = '0;
      src_row = '0;
      expected_writes.delete();
    end else begin
      if ($isunknown({in_stall, out_valid})) begin
        report_mismatch("handshake outputs unknown", {30'b0, in_stall, out_valid}, '0);
      end
      // Check the write transfer against the oldest prediction.
      if (out_valid === 1'b1 && !out_stall) begin
        if (expected_writes.size() == 0) begin
          report_mismatch("write with none expected, address",
                          32'(out_data.dest_address), '0);
        end else begin
          want = expected_writes.pop_front();
          if (out_data.dest_address !== want.dest_address) begin
            report_mismatch("dest_address", 32'(out_data.dest_address),
                            32'(want.dest_address));
          end
          if (out_data.red_out !== want.red_out) begin
            report_mismatch("red_out", 32'(out_data.red_out), 32'(want.red_out));
          end
          if (out_data.green_out !== want.green_out) begin
            report_mismatch("green_out", 32'(out_data.green_out), 32'(want.green_out));
          end
          if (out_data.blue_out !== want.blue_out) begin
            report_mismatch("blue_out", 32'(out_data.blue_out), 32'(want.blue_out));
          end
          if (out_data.block_last !== want.block_last) begin
            report_mismatch("block_last", 32'(out_data.block_last), 32'(want.block_last));
          end
          if (out_data.frame_end !== want.frame_end) begin
            report_mismatch("frame_end", 32'(out_data.frame_end), 32'(want.frame_end));
          end
          writes_checked++;
          if (want.frame_end) begin
            frames_closed++;
          end
        end
      end
      // A pixel transfer adds its whole block of writes.
      if (in_valid && in_stall === 1'b0) begin
        predict_block(in_data);
        pixels_taken++;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_RATIO: begin
            ratio_reg = cfg_data[RAT_W-1:0];
          end
          CFG_WIDTH: begin
            width_reg = cfg_data;
          end
          CFG_HEIGHT: begin
            height_reg = cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
    pending_writes = expected_writes.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Drives source pixels and register settings into the upscaler, applies random
// back-pressure on the write channel and reports the verdict from the checker.
module testbench;
  import irpu_pkg::*;

  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_PIXELS   = 300;
  localparam int DRAIN_CYCLES    = 80;
  localparam int HOLD_OFF_PHASE  = 2;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  in_pix_t              in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_wr_t              out_data;

  int fail_count;
  int pending_writes;
  int pixels_taken;
  int writes_checked;
  int frames_closed;
  int idle_cycles = 0;
  int settings_applied = 0;
  int random_sent = 0;
  bit hold_off_req = 0;
  bit hold_off_done = 0;

  integer_ratio_pixel_upscaler_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  upscale_write_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .pending_writes (pending_writes),
    .pixels_taken   (pixels_taken),
    .writes_checked (writes_checked),
    .frames_closed  (frames_closed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Gap length: usually a short one, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // One pixel transfer, preceded by the given number of idle cycles.
  task automatic send_pixel(input in_pix_t px, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_data <= 24'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic random_pixel(input bit gappy);
    logic [23:0] bits;
    bits = 24'($urandom);
    send_pixel(bits, (gappy && $urandom_range(0, 99) < 30) ? pick_gap() : 0);
    random_sent++;
  endtask

  // Lets every owed write come out, then waits with the input idle, before registers change.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_writes != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_geometry(input logic [CFG_DAT_W-1:0] ratio,
                              input logic [CFG_DAT_W-1:0] width,
                              input logic [CFG_DAT_W-1:0] height);
    wait_idle();
    program_reg(CFG_RATIO, ratio);
    program_reg(CFG_WIDTH, width);
    program_reg(CFG_HEIGHT, height);
    settings_applied++;
  endtask

  // Random settings: mostly small ratios and tiny frames so frames wrap often,
  // with the extremes and out-of-range values mixed in.
  task automatic random_geometry();
    int unsigned pick;
    logic [CFG_DAT_W-1:0] ratio;
    logic [CFG_DAT_W-1:0] width;
    logic [CFG_DAT_W-1:0] height;
    pick = $urandom_range(0, 19);
    if (pick < 2) begin
      ratio = '0;
    end else if (pick < 4) begin
      ratio = CFG_DAT_W'(MAX_RATIO);
    end else if (pick < 5) begin
      ratio = CFG_DAT_W'($urandom_range(MAX_RATIO + 1, 15));
    end else begin
      ratio = CFG_DAT_W'($urandom_range(1, 4));
    end
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      width = CFG_DAT_W'($urandom_range(1, 8));
    end else if (pick < 8) begin
      width = '0;
    end else if (pick < 9) begin
      width = CFG_DAT_W'($urandom_range(MAX_WIDTH, 2047));
    end else begin
      width = CFG_DAT_W'($urandom_range(1, MAX_WIDTH));
    end
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      height = CFG_DAT_W'($urandom_range(1, 6));
    end else if (pick < 8) begin
      height = '0;
    end else if (pick < 9) begin
      height = CFG_DAT_W'($urandom_range(MAX_HEIGHT, 2047));
    end else begin
      height = CFG_DAT_W'($urandom_range(1, MAX_HEIGHT));
    end
    set_geometry(ratio, width, height);
  endtask

  // Write channel back-pressure, with its own modes and one long hold-off.
  initial begin
    int run_left;
    int stall_left;
    int mode;
    run_left = 0;
    stall_left = 0;
    mode = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_off_done) begin
        stall_left = HOLD_OFF_CYCLES;
        hold_off_done = 1;
      end
      if (run_left == 0) begin
        mode = $urandom_range(0, 3);
        run_left = $urandom_range(20, 150);
      end
      run_left--;
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (mode != 0 && $urandom_range(0, 99) < 25) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  // Counts cycles in which no transfer and no register write happens.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // Main stimulus.
  initial begin
    int phase;
    int count;
    bit gappy;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: color extremes and alternating bit patterns.
    send_pixel(24'h000000, 0);
    send_pixel(24'hFFFFFF, 0);
    send_pixel(24'hAA55AA, 1);
    send_pixel(24'h55AA55, 0);

    // Zero ratio and zero sizes act as one: every pixel closes a frame.
    set_geometry(0, 0, 0);
    send_pixel(24'h123456, 0);
    send_pixel(24'hFEDCBA, 0);
    send_pixel(24'h800080, 2);

    // Oversized ratio and sizes are held at their limits.
    set_geometry(15, 2047, 2047);
    send_pixel(24'hFF0000, 0);
    send_pixel(24'h00FF00, 0);
    set_geometry(CFG_DAT_W'(MAX_RATIO + 1), CFG_DAT_W'(MAX_WIDTH), CFG_DAT_W'(MAX_HEIGHT));
    send_pixel(24'h0000FF, 0);

    // Small frame entered mid-row, then the width shrinks below the current column.
    set_geometry(3, 5, 2);
    repeat (4) random_pixel(0);
    set_geometry(2, 1, 2);
    repeat (3) random_pixel(1);

    // Height shrinks below the current row.
    set_geometry(1, 4, 3);
    repeat (5) random_pixel(0);
    set_geometry(1, 4, 1);
    repeat (2) random_pixel(0);

    // Random phases with random settings; one phase runs into a long receiver hold-off.
    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_PIXELS) begin
      if (phase == HOLD_OFF_PHASE) begin
        set_geometry(4, 3, 3);
        hold_off_req = 1;
        gappy = 0;
      end else begin
        random_geometry();
        gappy = $urandom_range(0, 2) != 0;
      end
      count = $urandom_range(20, 40);
      repeat (count) random_pixel(gappy);
      phase++;
    end
    set_geometry(1, 1, 1);
    random_pixel(0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Covered %0d source pixels, %0d destination writes checked, %0d frame ends.",
             pixels_taken, writes_checked, frames_closed);
    $display("Register settings applied: %0d, including out-of-range ratios and sizes.",
             settings_applied);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
